### hw/rtl/fit_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// fit_block_allocator_assert.svh
// Assertion macros for the allocator's checker file.
// ----------------------------------------------------------------------------
`ifndef FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fit_block_allocator assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fit_block_allocator assertion failed");

`endif

### hw/rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and constants of the fit block allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int BASE_W   = 20;
  localparam int IDX_W    = 4;
  localparam int SIZE_W   = 16;
  localparam int COUNT_W  = 5;
  localparam int REG_IDX_W = 1;
  localparam int CFG_W    = 5;

  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = COUNT_W'(16);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_FIT_MODE    = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  // fit modes
  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_WORST = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  load_index;
    logic [SIZE_W-1:0] size;
  } fba_in_t;

  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  chosen_block;
    logic [BASE_W-1:0] block_base;
    logic [SIZE_W-1:0] remaining;
  } fba_out_t;

  // control of the search token that walks the cell chain
  typedef struct packed {
    logic vld;
    logic found;
  } fba_tok_t;

  // control of the write bus broadcast to all cells
  typedef struct packed {
    logic en;
    logic load;
  } fba_wr_t;

endpackage

### hw/rtl/fba_cell.sv
// ----------------------------------------------------------------------------
// fba_cell
// One block slot: holds free space and base, updates the passing search token.
// ----------------------------------------------------------------------------
module fba_cell #(
  parameter int SIZE_BITS = fba_pkg::SIZE_BITS_DEF,
  parameter int IDX_W     = 4,
  parameter int CELL_ID   = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fit_mode,
  input  logic [fba_pkg::COUNT_W-1:0]   block_count,
  input  logic [SIZE_BITS-1:0]          req,
  input  fba_pkg::fba_wr_t              wr,
  input  logic [IDX_W-1:0]              wr_idx,
  input  logic [SIZE_BITS-1:0]          wr_free,
  input  logic [fba_pkg::BASE_W-1:0]    wr_base,
  input  fba_pkg::fba_tok_t             tin,
  input  logic [IDX_W-1:0]              tin_pick,
  input  logic [SIZE_BITS-1:0]          tin_free,
  input  logic [fba_pkg::BASE_W-1:0]    tin_base,
  output fba_pkg::fba_tok_t             tout_r,
  output logic [IDX_W-1:0]              tout_pick_r,
  output logic [SIZE_BITS-1:0]          tout_free_r,
  output logic [fba_pkg::BASE_W-1:0]    tout_base_r
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

  logic [SIZE_BITS-1:0]       free_r;
  logic [fba_pkg::BASE_W-1:0] base_r;
  logic                       in_use;
  logic                       fits;
  logic                       take;
  logic                       sel;

  assign in_use = 32'(block_count) > 32'(CELL_ID);
  assign fits   = in_use && (req <= free_r);
  // first fit keeps the earliest hit, worst fit replaces on strictly more space
  assign take   = tin.vld && fits &&
                  (!tin.found || (fit_mode == fba_pkg::FIT_WORST && free_r > tin_free));
  assign sel    = wr.en && (wr_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tout_r <= '0;
    end else begin
      tout_r.vld   <= tin.vld;
      tout_r.found <= tin.found || take;
    end
  end

  always_ff @(posedge clk) begin
    tout_pick_r <= take ? MY_IDX : tin_pick;
    tout_free_r <= take ? free_r : tin_free;
    tout_base_r <= take ? base_r : tin_base;
    if (sel) begin
      free_r <= wr_free;
      if (wr.load) begin
        base_r <= wr_base;
      end
    end
  end

endmodule

### hw/rtl/fit_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_block_allocator
// Fixed-partition allocator with first-fit and worst-fit search.
// ----------------------------------------------------------------------------
// A load item sets one block's size and free space, and gives the block the
// running sum of earlier loads as its base address. Its result passes through
// the result register and the done state into the output register. An
// allocate item sends a search token down a chain of MAX_BLOCKS cells, one cell
// per cycle: cell 0 sees the launch strobe right after acceptance, the token
// passes through the chain, the grant is committed, and the result is handed
// out to the output register. One item is worked on at a time. The next is
// taken as soon as the previous result has moved into the output register,
// even if that result still waits there. Blocks that were never loaded hold
// no valid state and must not be searched.
// ----------------------------------------------------------------------------
module fit_block_allocator #(
  parameter int MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fba_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fba_pkg::fba_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fba_pkg::fba_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [fba_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [fba_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BW    = fba_pkg::BASE_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t                          state_r;
  logic                            fit_mode_r;
  logic [fba_pkg::COUNT_W-1:0]     block_count_r;
  logic [BW-1:0]                   load_total_r;
  logic [SIZE_BITS-1:0]            req_r;
  logic                            launch_r;
  fba_pkg::fba_out_t               res_r;
  logic                            out_valid_r;
  fba_pkg::fba_out_t               out_data_r;

  // search token chain: entry j feeds cell j, entry j+1 is its output
  fba_pkg::fba_tok_t               tok     [MAX_BLOCKS+1];
  logic [IDX_W-1:0]                tok_pick[MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0]            tok_free[MAX_BLOCKS+1];
  logic [BW-1:0]                   tok_base[MAX_BLOCKS+1];

  // cell write bus
  fba_pkg::fba_wr_t                wr;
  logic [IDX_W-1:0]                wr_idx;
  logic [SIZE_BITS-1:0]            wr_free;

  logic                            in_acc;
  logic                            is_load;
  logic                            ld_ok;
  logic [31:0]                     size_ext;
  logic [SIZE_BITS-1:0]            req_in;
  logic [31:0]                     req_in32;
  logic                            finish;
  logic [SIZE_BITS-1:0]            new_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_acc   = in_valid && in_ready;
  assign is_load  = (in_data.kind == fba_pkg::KIND_LOAD);
  assign ld_ok    = 32'(in_data.load_index) < 32'(MAX_BLOCKS);
  // trim the request to the stored size width
  assign size_ext = 32'(in_data.size);
  assign req_in   = size_ext[SIZE_BITS-1:0];
  assign req_in32 = 32'(req_in);

  assign finish   = (state_r == ST_SCAN) && tok[MAX_BLOCKS].vld;
  assign new_free = tok_free[MAX_BLOCKS] - req_r;

  // Drive the chain head from the launch strobe with an empty best-so-far.
  assign tok[0]      = '{vld: launch_r, found: 1'b0};
  assign tok_pick[0] = '0;
  assign tok_free[0] = '0;
  assign tok_base[0] = '0;

  // One write bus serves both loads (size and base) and grant commits (free).
  always_comb begin
    wr.load = in_acc && is_load;
    wr.en   = (wr.load && ld_ok) || (finish && tok[MAX_BLOCKS].found);
    wr_idx  = wr.load ? IDX_W'(in_data.load_index) : tok_pick[MAX_BLOCKS];
    wr_free = wr.load ? req_in : new_free;
  end

  for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
    fba_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .CELL_ID   (j)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .fit_mode    (fit_mode_r),
      .block_count (block_count_r),
      .req         (req_r),
      .wr          (wr),
      .wr_idx      (wr_idx),
      .wr_free     (wr_free),
      .wr_base     (load_total_r),
      .tin         (tok[j]),
      .tin_pick    (tok_pick[j]),
      .tin_free    (tok_free[j]),
      .tin_base    (tok_base[j]),
      .tout_r      (tok[j+1]),
      .tout_pick_r (tok_pick[j+1]),
      .tout_free_r (tok_free[j+1]),
      .tout_base_r (tok_base[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fit_mode_r    <= fba_pkg::FIT_WORST;
      block_count_r <= fba_pkg::BLOCK_COUNT_RST;
      load_total_r  <= '0;
      launch_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      launch_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          fba_pkg::REG_FIT_MODE:    fit_mode_r    <= cfg_wdata[0];
          fba_pkg::REG_BLOCK_COUNT: block_count_r <= cfg_wdata;
        endcase
      end

      // drop the output item once taken
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_load) begin
              if (ld_ok) begin
                load_total_r <= load_total_r + req_in32[BW-1:0];
                res_r <= '{granted: 1'b1, chosen_block: in_data.load_index,
                           block_base: load_total_r,
                           remaining: fba_pkg::SIZE_W'(req_in)};
              end else begin
                res_r <= '0;
              end
              state_r <= ST_DONE;
            end else begin
              // latch the request and launch the token next cycle
              req_r    <= req_in;
              launch_r <= 1'b1;
              state_r  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (finish) begin
            if (tok[MAX_BLOCKS].found) begin
              res_r <= '{granted: 1'b1,
                         chosen_block: fba_pkg::IDX_W'(tok_pick[MAX_BLOCKS]),
                         block_base: tok_base[MAX_BLOCKS],
                         remaining: fba_pkg::SIZE_W'(new_free)};
            end else begin
              res_r <= '0;
            end
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold the result until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/fba_checker.sv
// ----------------------------------------------------------------------------
// fba_checker
// Port-level checks of the fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fit_block_allocator_assert.svh"

module fba_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input fba_pkg::fba_in_t              in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input fba_pkg::fba_out_t             out_data
);

  logic in_acc;
  logic load_acc;
  logic out_stall;
  logic fields_zero;

  assign in_acc      = in_valid && in_ready;
  assign load_acc    = in_acc && (in_data.kind == fba_pkg::KIND_LOAD) &&
                       (!out_valid || out_ready);
  assign out_stall   = out_valid && !out_ready;
  assign fields_zero = (out_data.chosen_block == '0) && (out_data.block_base == '0) &&
                       (out_data.remaining == '0);

  // a stalled result holds
  `FBA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data))

  // one item at a time: ready drops right after an acceptance
  `FBA_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready)

  // a refusal carries all-zero fields
  `FBA_ASSERT_NOW(a_nogrant_zero, out_valid && !out_data.granted, fields_zero)

  // a load with a free output slot is answered through the done state, with the output empty in between
  `FBA_ASSERT_NEXT(a_load_latency, load_acc, !out_valid ##1 out_valid)

endmodule

bind fit_block_allocator fba_checker u_fba_checker (.*);
